/* hw/rtl/bsl_pkg.sv */
package bsl_pkg;

   localparam int CAPACITY_DEF = 256;
   localparam int POS_W = 12;

   typedef enum logic [3:0] {
      CMD_INS_HEAD = 4'd0,
      CMD_INS_TAIL = 4'd1,
      CMD_RM_HEAD  = 4'd2,
      CMD_RM_TAIL  = 4'd3,
      CMD_RM_INDEX = 4'd4,
      CMD_RD_INDEX = 4'd5,
      CMD_RD_HEAD  = 4'd6,
      CMD_RD_TAIL  = 4'd7,
      CMD_CLEAR    = 4'd8
   } cmd_type;

   typedef struct packed {
      logic [7:0] symbol;
      logic [7:0] y;
      logic [7:0] x;
   } entry_type;

   typedef struct packed {
      logic             shift_right;
      logic             load;
      logic             shift_left;
      logic             rd_en;
      logic [POS_W-1:0] pos;
      entry_type        item;
   } ctrl_type;

endpackage

/* hw/rtl/bsl_cell.sv */
module bsl_cell #(
   parameter int INDEX = 0
) (
   input  logic              clock,
   input  bsl_pkg::ctrl_type ctrl,
   input  bsl_pkg::entry_type left_entry,
   input  bsl_pkg::entry_type right_entry,
   input  bsl_pkg::entry_type rd_prev,
   output bsl_pkg::entry_type entry_out,
   output bsl_pkg::entry_type rd_out
);

   localparam logic [bsl_pkg::POS_W-1:0] MY_POS = bsl_pkg::POS_W'(INDEX);

   bsl_pkg::entry_type entry_ff;
   bsl_pkg::entry_type entry_in;
   bsl_pkg::entry_type rd_ff;
   bsl_pkg::entry_type rd_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.shift_right) begin
         entry_in = left_entry;
      end else if (ctrl.load && (ctrl.pos == MY_POS)) begin
         entry_in = ctrl.item;
      end else if (ctrl.shift_left && (MY_POS >= ctrl.pos)) begin
         entry_in = right_entry;
      end
   end

   always_comb begin
      rd_in = rd_ff;
      if (ctrl.rd_en) begin
         rd_in = (ctrl.pos == MY_POS) ? entry_ff : rd_prev;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      rd_ff    <= rd_in;
   end

   assign entry_out = entry_ff;
   assign rd_out    = rd_ff;

endmodule

/* hw/rtl/bounded_shifting_list.sv */
// Non-read commands and failed reads: the result strobe comes in the cycle after the item is taken.
// A valid read walks the cell chain: its result comes when the walk ends, in the same cycle that busy falls.
// Busy is high during that walk and no new item is taken until it ends; other commands
// are taken at one item per cycle while no walk runs. The receiver cannot stall the result.
// Reset clears the list size and the control state; the cell contents are not reset.
module bounded_shifting_list #(
   parameter int CAPACITY = bsl_pkg::CAPACITY_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [3:0]        req_cmd,
   input  logic [7:0]        req_pos_x,
   input  logic [7:0]        req_pos_y,
   input  logic [7:0]        req_symbol_in,
   input  logic [7:0]        req_index,
   output logic              rsp_strobe,
   output logic signed [8:0] rsp_out_x,
   output logic signed [8:0] rsp_out_y,
   output logic [7:0]        rsp_out_symbol,
   output logic [8:0]        rsp_list_size,
   output logic              rsp_status
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;
   localparam int POS_W = bsl_pkg::POS_W;

   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    busy_ff, busy_in;
   logic [IDX_W-1:0]        walk_ff, walk_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic                    strobe_ff, strobe_in;
   logic                    chain_sel_ff, chain_sel_in;
   logic signed [8:0]       x_ff, x_in;
   logic signed [8:0]       y_ff, y_in;
   logic [7:0]              symbol_ff, symbol_in;
   logic                    status_ff, status_in;

   logic                    accept;
   logic                    full;
   logic                    empty;
   logic                    idx_ok;
   logic [POS_W-1:0]        tail_pos;
   bsl_pkg::ctrl_type       ctrl;
   bsl_pkg::entry_type      item;
   bsl_pkg::entry_type      entry_w [CAPACITY];
   bsl_pkg::entry_type      rd_w    [CAPACITY];
   bsl_pkg::entry_type      left_w  [CAPACITY];
   bsl_pkg::entry_type      right_w [CAPACITY];

   assign accept   = start && !busy_ff;
   assign full     = (count_ff == CNT_W'(CAPACITY));
   assign empty    = (count_ff == '0);
   assign idx_ok   = (CMP_W'(req_index) < CMP_W'(count_ff));
   assign tail_pos = POS_W'(count_ff - CNT_W'(1));
   assign item     = '{symbol: req_symbol_in, y: req_pos_y, x: req_pos_x};

   always_comb begin
      ctrl         = '0;
      ctrl.item    = item;
      count_in     = count_ff;
      busy_in      = busy_ff;
      walk_in      = walk_ff;
      pos_in       = pos_ff;
      strobe_in    = 1'b0;
      chain_sel_in = chain_sel_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      symbol_in    = symbol_ff;
      status_in    = status_ff;

      if (busy_ff) begin
         ctrl.rd_en = 1'b1;
         ctrl.pos   = pos_ff;
         walk_in    = walk_ff + IDX_W'(1);
         if (walk_ff == IDX_W'(CAPACITY - 1)) begin
            busy_in      = 1'b0;
            strobe_in    = 1'b1;
            chain_sel_in = 1'b1;
            status_in    = 1'b0;
         end
      end else if (accept) begin
         strobe_in    = 1'b1;
         chain_sel_in = 1'b0;
         x_in         = '0;
         y_in         = '0;
         symbol_in    = '0;
         status_in    = 1'b0;
         unique case (req_cmd) inside
            bsl_pkg::CMD_INS_HEAD: begin
               if (full) begin
                  status_in = 1'b1;
               end else begin
                  ctrl.shift_right = 1'b1;
                  count_in         = count_ff + CNT_W'(1);
               end
            end
            bsl_pkg::CMD_INS_TAIL: begin
               if (full) begin
                  status_in = 1'b1;
               end else begin
                  ctrl.load = 1'b1;
                  ctrl.pos  = POS_W'(count_ff);
                  count_in  = count_ff + CNT_W'(1);
               end
            end
            bsl_pkg::CMD_RM_HEAD: begin
               if (empty) begin
                  status_in = 1'b1;
               end else begin
                  ctrl.shift_left = 1'b1;
                  ctrl.pos        = '0;
                  count_in        = count_ff - CNT_W'(1);
               end
            end
            bsl_pkg::CMD_RM_TAIL: begin
               if (empty) begin
                  status_in = 1'b1;
               end else begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
            bsl_pkg::CMD_RM_INDEX: begin
               if (!idx_ok) begin
                  status_in = 1'b1;
               end else begin
                  ctrl.shift_left = 1'b1;
                  ctrl.pos        = POS_W'(req_index);
                  count_in        = count_ff - CNT_W'(1);
               end
            end
            bsl_pkg::CMD_RD_INDEX, bsl_pkg::CMD_RD_HEAD, bsl_pkg::CMD_RD_TAIL: begin
               if ((req_cmd == bsl_pkg::CMD_RD_INDEX) ? !idx_ok : empty) begin
                  x_in      = -9'sd1;
                  y_in      = -9'sd1;
                  status_in = 1'b1;
               end else begin
                  strobe_in = 1'b0;
                  busy_in   = 1'b1;
                  walk_in   = '0;
                  if (req_cmd == bsl_pkg::CMD_RD_INDEX) begin
                     pos_in = POS_W'(req_index);
                  end else if (req_cmd == bsl_pkg::CMD_RD_HEAD) begin
                     pos_in = '0;
                  end else begin
                     pos_in = tail_pos;
                  end
               end
            end
            bsl_pkg::CMD_CLEAR: begin
               count_in = '0;
            end
            default: begin
               status_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         walk_ff      <= '0;
         strobe_ff    <= 1'b0;
         chain_sel_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         walk_ff      <= walk_in;
         strobe_ff    <= strobe_in;
         chain_sel_ff <= chain_sel_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      symbol_ff <= symbol_in;
      status_ff <= status_in;
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == 0) begin : g_head
         assign left_w[g] = item;
      end else begin : g_body
         assign left_w[g] = entry_w[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign right_w[g] = entry_w[g];
      end else begin : g_inner
         assign right_w[g] = entry_w[g+1];
      end

      bsl_cell #(
         .INDEX(g)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .left_entry (left_w[g]),
         .right_entry(right_w[g]),
         .rd_prev    ((g == 0) ? bsl_pkg::entry_type'('0) : rd_w[(g == 0) ? 0 : g-1]),
         .entry_out  (entry_w[g]),
         .rd_out     (rd_w[g])
      );
   end

   assign busy           = busy_ff;
   assign rsp_strobe     = strobe_ff;
   assign rsp_out_x      = chain_sel_ff ? $signed({1'b0, rd_w[CAPACITY-1].x}) : x_ff;
   assign rsp_out_y      = chain_sel_ff ? $signed({1'b0, rd_w[CAPACITY-1].y}) : y_ff;
   assign rsp_out_symbol = chain_sel_ff ? rd_w[CAPACITY-1].symbol : symbol_ff;
   assign rsp_list_size  = 9'(count_ff);
   assign rsp_status     = status_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("List size exceeds capacity.");

   assert property (@(posedge clock) disable iff (reset)
      (accept && (req_cmd != bsl_pkg::CMD_RD_INDEX) && (req_cmd != bsl_pkg::CMD_RD_HEAD)
       && (req_cmd != bsl_pkg::CMD_RD_TAIL)) |=> (strobe_ff && !busy_ff))
      else $error("A non-read item gave no result in the next cycle.");

   assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && strobe_ff))
      else $error("Result strobe while a read walk is still running.");

   assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> (strobe_ff && chain_sel_ff && !status_ff))
      else $error("A finished read walk gave no result.");

   assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> ($stable(count_ff) && $stable(pos_ff)))
      else $error("List changed during a read walk.");

endmodule

/* tb/sv/bounded_shifting_list_checker.sv */
module bounded_shifting_list_checker #(
   parameter int CAPACITY = bsl_pkg::CAPACITY_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic [3:0]        req_cmd,
   input  logic [7:0]        req_pos_x,
   input  logic [7:0]        req_pos_y,
   input  logic [7:0]        req_symbol_in,
   input  logic [7:0]        req_index,
   input  logic              rsp_strobe,
   input  logic signed [8:0] rsp_out_x,
   input  logic signed [8:0] rsp_out_y,
   input  logic [7:0]        rsp_out_symbol,
   input  logic [8:0]        rsp_list_size,
   input  logic              rsp_status,
   output int                errors,
   output int                pending
);

   typedef struct packed {
      logic signed [8:0] x;
      logic signed [8:0] y;
      logic [7:0]        symbol;
      logic [8:0]        size;
      logic              status;
   } reply_type;

   bsl_pkg::entry_type list_entries [CAPACITY];
   int unsigned        list_count;
   reply_type          expected_replies [$];
   int                 mismatch_count;

   function automatic void set_read(ref reply_type r, input bsl_pkg::entry_type e);
      r.x = $signed({1'b0, e.x});
      r.y = $signed({1'b0, e.y});
      r.symbol = e.symbol;
   endfunction

   function automatic void set_failed_read(ref reply_type r);
      r.x = '1;
      r.y = '1;
      r.symbol = '0;
      r.status = 1'b1;
   endfunction

   function automatic void shift_toward_head(input int unsigned from);
      for (int unsigned i = from; i + 1 < list_count; i++) begin
         list_entries[i] = list_entries[i + 1];
      end
      list_count--;
   endfunction

   function automatic reply_type apply_list_command(input logic [3:0] op,
                                                    input bsl_pkg::entry_type e,
                                                    input logic [7:0] idx);
      reply_type r;
      r = '0;
      case (op)
         bsl_pkg::CMD_INS_HEAD: begin
            if (list_count < CAPACITY) begin
               for (int unsigned i = list_count; i > 0; i--) begin
                  list_entries[i] = list_entries[i - 1];
               end
               list_entries[0] = e;
               list_count++;
            end else begin
               r.status = 1'b1;
            end
         end
         bsl_pkg::CMD_INS_TAIL: begin
            if (list_count < CAPACITY) begin
               list_entries[list_count] = e;
               list_count++;
            end else begin
               r.status = 1'b1;
            end
         end
         bsl_pkg::CMD_RM_HEAD: begin
            if (list_count > 0) shift_toward_head(0);
            else r.status = 1'b1;
         end
         bsl_pkg::CMD_RM_TAIL: begin
            if (list_count > 0) list_count--;
            else r.status = 1'b1;
         end
         bsl_pkg::CMD_RM_INDEX: begin
            if (idx < list_count) shift_toward_head(idx);
            else r.status = 1'b1;
         end
         bsl_pkg::CMD_RD_INDEX: begin
            if (idx < list_count) set_read(r, list_entries[idx]);
            else set_failed_read(r);
         end
         bsl_pkg::CMD_RD_HEAD: begin
            if (list_count > 0) set_read(r, list_entries[0]);
            else set_failed_read(r);
         end
         bsl_pkg::CMD_RD_TAIL: begin
            if (list_count > 0) set_read(r, list_entries[list_count - 1]);
            else set_failed_read(r);
         end
         bsl_pkg::CMD_CLEAR: begin
            list_count = 0;
         end
         default: begin
            r.status = 1'b1;
         end
      endcase
      r.size = 9'(list_count);
      return r;
   endfunction

   function automatic void check_field(input string name, input logic signed [31:0] want,
                                       input logic signed [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      reply_type want;
      bsl_pkg::entry_type item;
      if (reset) begin
         list_count = 0;
         expected_replies.delete();
      end else begin
         if (rsp_strobe) begin
            if (expected_replies.size() == 0) begin
               $error("reply with no item outstanding: x %0d y %0d symbol %0d size %0d",
                      rsp_out_x, rsp_out_y, rsp_out_symbol, rsp_list_size);
               mismatch_count++;
            end else begin
               want = expected_replies.pop_front();
               check_field("out_x", want.x, rsp_out_x);
               check_field("out_y", want.y, rsp_out_y);
               check_field("out_symbol", want.symbol, rsp_out_symbol);
               check_field("list_size", want.size, rsp_list_size);
               check_field("status", want.status, rsp_status);
            end
         end
         if (start && !busy) begin
            item.x = req_pos_x;
            item.y = req_pos_y;
            item.symbol = req_symbol_in;
            expected_replies.push_back(apply_list_command(req_cmd, item, req_index));
         end
      end
      pending <= expected_replies.size();
      errors <= mismatch_count;
   end

endmodule

/* tb/sv/bounded_shifting_list_tb.sv */
module bounded_shifting_list_tb;

   localparam int CAPACITY = bsl_pkg::CAPACITY_DEF;
   localparam int ITEM_TARGET = 1600;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam logic [3:0] CMD_FIRST_UNUSED = 4'd9;
   localparam logic [3:0] CMD_LAST_UNUSED = 4'd15;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [3:0]        req_cmd = '0;
   logic [7:0]        req_pos_x = '0;
   logic [7:0]        req_pos_y = '0;
   logic [7:0]        req_symbol_in = '0;
   logic [7:0]        req_index = '0;
   logic              rsp_strobe;
   logic signed [8:0] rsp_out_x;
   logic signed [8:0] rsp_out_y;
   logic [7:0]        rsp_out_symbol;
   logic [8:0]        rsp_list_size;
   logic              rsp_status;

   int failures;
   int outstanding;
   int items_sent = 0;
   int idle_percent = 0;
   int stall_cycles = 0;

   always #5 clock = ~clock;

   bounded_shifting_list #(.CAPACITY(CAPACITY)) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_cmd(req_cmd),
      .req_pos_x(req_pos_x),
      .req_pos_y(req_pos_y),
      .req_symbol_in(req_symbol_in),
      .req_index(req_index),
      .rsp_strobe(rsp_strobe),
      .rsp_out_x(rsp_out_x),
      .rsp_out_y(rsp_out_y),
      .rsp_out_symbol(rsp_out_symbol),
      .rsp_list_size(rsp_list_size),
      .rsp_status(rsp_status)
   );

   bounded_shifting_list_checker #(.CAPACITY(CAPACITY)) list_checker (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_cmd(req_cmd),
      .req_pos_x(req_pos_x),
      .req_pos_y(req_pos_y),
      .req_symbol_in(req_symbol_in),
      .req_index(req_index),
      .rsp_strobe(rsp_strobe),
      .rsp_out_x(rsp_out_x),
      .rsp_out_y(rsp_out_y),
      .rsp_out_symbol(rsp_out_symbol),
      .rsp_list_size(rsp_list_size),
      .rsp_status(rsp_status),
      .errors(failures),
      .pending(outstanding)
   );

   task automatic send_item(input logic [3:0] op, input logic [7:0] x, input logic [7:0] y,
                            input logic [7:0] sym, input logic [7:0] idx);
      while ($urandom_range(99) < idle_percent) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_cmd <= op;
      req_pos_x <= x;
      req_pos_y <= y;
      req_symbol_in <= sym;
      req_index <= idx;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_random(input logic [3:0] op);
      logic [7:0] idx;
      idx = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(15));
      send_item(op, 8'($urandom), 8'($urandom), 8'($urandom), idx);
   endtask

   task automatic wait_for_replies();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   function automatic logic [3:0] pick_command();
      int roll;
      roll = $urandom_range(99);
      if (roll < 18) return bsl_pkg::CMD_INS_HEAD;
      if (roll < 35) return bsl_pkg::CMD_INS_TAIL;
      if (roll < 43) return bsl_pkg::CMD_RM_HEAD;
      if (roll < 51) return bsl_pkg::CMD_RM_TAIL;
      if (roll < 59) return bsl_pkg::CMD_RM_INDEX;
      if (roll < 77) return bsl_pkg::CMD_RD_INDEX;
      if (roll < 85) return bsl_pkg::CMD_RD_HEAD;
      if (roll < 93) return bsl_pkg::CMD_RD_TAIL;
      if (roll < 94) return bsl_pkg::CMD_CLEAR;
      return 4'($urandom_range(CMD_LAST_UNUSED, CMD_FIRST_UNUSED));
   endfunction

   function automatic logic [3:0] pick_removal();
      case ($urandom_range(3))
         0: return bsl_pkg::CMD_RM_HEAD;
         1: return bsl_pkg::CMD_RM_INDEX;
         default: return bsl_pkg::CMD_RM_TAIL;
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin
      int segment;
      int phase;
      segment = 0;
      phase = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      idle_percent = 12;
      send_item(bsl_pkg::CMD_RD_HEAD, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(bsl_pkg::CMD_RD_TAIL, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(bsl_pkg::CMD_RD_INDEX, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(bsl_pkg::CMD_RM_HEAD, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(bsl_pkg::CMD_RM_TAIL, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(bsl_pkg::CMD_RM_INDEX, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(bsl_pkg::CMD_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(CMD_FIRST_UNUSED, 8'hff, 8'hff, 8'hff, 8'hff);
      send_item(CMD_LAST_UNUSED, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(bsl_pkg::CMD_INS_HEAD, 8'hff, 8'hff, 8'hff, 8'hff);
      send_item(bsl_pkg::CMD_INS_TAIL, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(bsl_pkg::CMD_INS_HEAD, 8'haa, 8'h55, 8'h81, 8'h00);
      send_item(bsl_pkg::CMD_INS_TAIL, 8'h5a, 8'ha5, 8'h7e, 8'h00);
      send_item(bsl_pkg::CMD_RD_HEAD, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(bsl_pkg::CMD_RD_TAIL, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(bsl_pkg::CMD_RD_INDEX, 8'h00, 8'h00, 8'h00, 8'h01);
      send_item(bsl_pkg::CMD_RD_INDEX, 8'h00, 8'h00, 8'h00, 8'h03);
      send_item(bsl_pkg::CMD_RD_INDEX, 8'h00, 8'h00, 8'h00, 8'h04);
      send_item(bsl_pkg::CMD_RD_INDEX, 8'h00, 8'h00, 8'h00, 8'hff);
      send_item(bsl_pkg::CMD_RM_INDEX, 8'h00, 8'h00, 8'h00, 8'h01);
      send_item(bsl_pkg::CMD_RM_INDEX, 8'h00, 8'h00, 8'h00, 8'hff);
      send_item(bsl_pkg::CMD_RM_HEAD, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(bsl_pkg::CMD_RM_TAIL, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(bsl_pkg::CMD_RD_INDEX, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(bsl_pkg::CMD_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(bsl_pkg::CMD_RD_HEAD, 8'h00, 8'h00, 8'h00, 8'h00);

      while (items_sent < ITEM_TARGET) begin
         if (phase == 0 && items_sent >= ITEM_TARGET / 3) begin
            wait_for_replies();
            idle_percent = 84;
            phase = 1;
         end else if (phase == 1 && items_sent >= 2 * ITEM_TARGET / 3) begin
            wait_for_replies();
            idle_percent = 0;
            phase = 2;
         end
         case (segment % 6)
            2: begin
               repeat (CAPACITY + 6) begin
                  send_random($urandom_range(1) ? bsl_pkg::CMD_INS_HEAD
                                                : bsl_pkg::CMD_INS_TAIL);
               end
            end
            5: begin
               repeat (CAPACITY + 6) send_random(pick_removal());
            end
            default: begin
               repeat ($urandom_range(80, 20)) send_random(pick_command());
            end
         endcase
         segment++;
      end

      wait_for_replies();
      repeat (CAPACITY + 8) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
